FILE: hdl/glu_pkg.sv
package glu_pkg;

    localparam int OPND_W = 63;

    typedef struct packed {
        logic [OPND_W-1:0] operand_a;
        logic [OPND_W-1:0] operand_b;
    } glu_in_t;

    typedef struct packed {
        logic [OPND_W-1:0] gcd_value;
        logic [OPND_W-1:0] lcm_value;
        logic              lcm_overflow;
    } glu_out_t;

endpackage

FILE: hdl/gcd_lcm_unit_top.sv
// GCD / LCM unit.
// Input channel: drive operand and pulse start while busy is low; the item is
// taken at that clock edge and busy rises on the next cycle.
// Output channel: done is high for exactly one cycle with result valid; the
// receiver cannot stall, so it must capture result in that cycle.
// Operand bits at and above OPERAND_BITS are ignored.
// The gcd is found by Euclidean remainder steps (0 to about 90 at 63 bits)
// on one shared restoring divider that retires one quotient bit per cycle.
// The lcm then reuses that divider once for a / gcd and a bit-serial
// shift-add multiplier for (a / gcd) * b; with a zero operand the lcm steps
// are skipped. One item is in work at a time; busy stays high until the
// cycle after done, when the next item can be taken.
// An lcm that does not fit OPERAND_BITS bits saturates to all ones there and
// raises lcm_overflow. Either operand zero gives lcm 0, no overflow.
// Reset returns the sequencer to idle; no item is in flight after it.
module gcd_lcm_unit_top
    import glu_pkg::*;
#(
    parameter int OPERAND_BITS = 63
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    input  glu_in_t  operand,
    output logic     busy,
    output logic     done,
    output glu_out_t result
);

    localparam int N     = OPERAND_BITS;
    localparam int CNT_W = $clog2(N);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_TEST  = 3'd1;
    localparam logic [2:0] S_RDIV  = 3'd2;
    localparam logic [2:0] S_QDIV  = 3'd3;
    localparam logic [2:0] S_MUL   = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    logic [2:0]       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [N-1:0]     a_reg, a_next;
    logic [N-1:0]     b_reg, b_next;
    logic [N-1:0]     m_reg, m_next;
    logic [N-1:0]     n_reg, n_next;
    logic [N-1:0]     r_reg, r_next;
    logic [N-1:0]     g_reg, g_next;
    logic [N-1:0]     acc_reg, acc_next;
    logic             ovf_reg, ovf_next;

    logic [N:0]       rem_sh;
    logic [N:0]       rem_diff;
    logic             rem_ge;
    logic [N-1:0]     rem_new;
    logic [N-1:0]     quo_new;
    logic [N+1:0]     mul_sum;
    logic             last_bit;

    // shared restoring divide step
    always_comb
    begin
        rem_sh   = {r_reg, m_reg[N-1]};
        rem_diff = rem_sh - {1'b0, n_reg};
        rem_ge   = (rem_sh >= {1'b0, n_reg});
        rem_new  = rem_ge ? rem_diff[N-1:0] : rem_sh[N-1:0];
        quo_new  = {m_reg[N-2:0], rem_ge};
        mul_sum  = {1'b0, acc_reg, 1'b0} + (m_reg[N-1] ? {2'b00, b_reg} : '0);
        last_bit = (cnt_reg == CNT_W'(N - 1));
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        m_next     = m_reg;
        n_next     = n_reg;
        r_next     = r_reg;
        g_next     = g_reg;
        acc_next   = acc_reg;
        ovf_next   = ovf_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    a_next     = operand.operand_a[N-1:0];
                    b_next     = operand.operand_b[N-1:0];
                    m_next     = operand.operand_a[N-1:0];
                    n_next     = operand.operand_b[N-1:0];
                    state_next = S_TEST;
                end
            end
            S_TEST:
            begin
                r_next   = '0;
                cnt_next = '0;
                if (n_reg == '0)
                begin
                    g_next   = m_reg;
                    acc_next = '0;
                    ovf_next = 1'b0;
                    if (a_reg == '0 || b_reg == '0)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        m_next     = a_reg;
                        n_next     = m_reg;
                        state_next = S_QDIV;
                    end
                end
                else
                begin
                    state_next = S_RDIV;
                end
            end
            S_RDIV:
            begin
                r_next   = rem_new;
                m_next   = quo_new;
                cnt_next = cnt_reg + 1'b1;
                if (last_bit)
                begin
                    m_next     = n_reg;
                    n_next     = rem_new;
                    state_next = S_TEST;
                end
            end
            S_QDIV:
            begin
                r_next   = rem_new;
                m_next   = quo_new;
                cnt_next = cnt_reg + 1'b1;
                if (last_bit)
                begin
                    cnt_next   = '0;
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                // quotient MSB first; overflow is sticky since acc never shrinks
                m_next   = {m_reg[N-2:0], 1'b0};
                cnt_next = cnt_reg + 1'b1;
                if (!ovf_reg)
                begin
                    if (mul_sum[N+1:N] != 2'b00)
                    begin
                        ovf_next = 1'b1;
                    end
                    else
                    begin
                        acc_next = mul_sum[N-1:0];
                    end
                end
                if (last_bit)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg   <= a_next;
        b_reg   <= b_next;
        m_reg   <= m_next;
        n_reg   <= n_next;
        r_reg   <= r_next;
        g_reg   <= g_next;
        acc_reg <= acc_next;
        ovf_reg <= ovf_next;
    end

    assign busy = (state_reg != S_IDLE);
    assign done = (state_reg == S_DONE);

    always_comb
    begin
        result.gcd_value    = OPND_W'(g_reg);
        result.lcm_value    = ovf_reg ? OPND_W'({N{1'b1}}) : OPND_W'(acc_reg);
        result.lcm_overflow = ovf_reg;
    end

endmodule

FILE: hdl/glu_checker.sv
module glu_checker
    import glu_pkg::*;
(
    input logic     clk,
    input logic     rst_n,
    input logic     start,
    input logic     busy,
    input logic     done,
    input glu_out_t result
);

    // done only while an item is in work
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy)
        else $error("done without busy");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("item taken but busy low");

    // busy drops only right after the result strobe
    a_fall_done: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> $past(done))
        else $error("busy fell without done");

    // gcd 0 means both operands zero
    a_zero_lcm: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.gcd_value == '0) |->
            (result.lcm_value == '0 && !result.lcm_overflow))
        else $error("zero operands gave nonzero lcm");

    a_one_shot: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done longer than one cycle");

endmodule

bind gcd_lcm_unit_top glu_checker u_glu_checker (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .busy    (busy),
    .done    (done),
    .result  (result)
);

FILE: test/gcd_lcm_unit_top_test.sv
`timescale 1ns / 100ps

module gcd_lcm_unit_top_test;
    import glu_pkg::*;

    localparam bit [OPND_W-1:0] OPND_MAX = '1;
    localparam bit [OPND_W-1:0] BIT62 = 63'h4000_0000_0000_0000;
    localparam int DRAIN_CYCLES = 6200;

    typedef struct {
        glu_in_t  stim;
        bit       typed;
        glu_out_t want;
    } dir_row_t;

    logic     clk;
    logic     rst_n;
    logic     start;
    glu_in_t  operand;
    logic     busy;
    logic     done;
    glu_out_t result;

    glu_out_t    expected_results[$];
    glu_out_t    oldest_expected;
    dir_row_t    dir_rows[$];
    int unsigned mismatches;
    int unsigned items_sent;
    int unsigned results_seen;
    int unsigned overflow_seen;
    int unsigned zero_operand_items;
    int unsigned sender_idle_pct;

    gcd_lcm_unit_top i_dut
    (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .operand(operand),
        .busy(busy),
        .done(done),
        .result(result)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    function automatic glu_out_t gcd_lcm_predict(input glu_in_t x);
        bit [OPND_W-1:0]   m;
        bit [OPND_W-1:0]   n;
        bit [OPND_W-1:0]   r;
        bit [OPND_W-1:0]   q;
        bit [2*OPND_W-1:0] prod;
        glu_out_t          y;
        m = x.operand_a;
        n = x.operand_b;
        while (n != 0)
        begin
            r = m % n;
            m = n;
            n = r;
        end
        y.gcd_value    = m;
        y.lcm_value    = '0;
        y.lcm_overflow = 1'b0;
        if (x.operand_a != 0 && x.operand_b != 0)
        begin
            q    = x.operand_a / m;
            prod = {{OPND_W{1'b0}}, q} * {{OPND_W{1'b0}}, x.operand_b};
            if (prod > {{OPND_W{1'b0}}, OPND_MAX})
            begin
                y.lcm_value    = OPND_MAX;
                y.lcm_overflow = 1'b1;
            end
            else
            begin
                y.lcm_value = prod[OPND_W-1:0];
            end
        end
        return y;
    endfunction

    function automatic dir_row_t mk_row(input bit [OPND_W-1:0] a, input bit [OPND_W-1:0] b,
                                        input bit typed = 1'b0,
                                        input bit [OPND_W-1:0] g = '0,
                                        input bit [OPND_W-1:0] l = '0,
                                        input bit o = 1'b0);
        dir_row_t row;
        row.stim.operand_a    = a;
        row.stim.operand_b    = b;
        row.typed             = typed;
        row.want.gcd_value    = g;
        row.want.lcm_value    = l;
        row.want.lcm_overflow = o;
        return row;
    endfunction

    function automatic bit [OPND_W-1:0] rand_of_width(input int w);
        bit [63:0] raw;
        raw = {$urandom, $urandom};
        return raw[OPND_W-1:0] & ((63'd1 << w) - 63'd1);
    endfunction

    function automatic glu_in_t rand_operands();
        glu_in_t         x;
        bit [OPND_W-1:0] f0;
        bit [OPND_W-1:0] f1;
        bit [OPND_W-1:0] t;
        int              wg;
        int              k;
        int unsigned     pick;
        pick = $urandom_range(99);
        if (pick < 35)
        begin
            x.operand_a = rand_of_width($urandom_range(1, OPND_W));
            x.operand_b = rand_of_width($urandom_range(1, OPND_W));
        end
        else if (pick < 70)
        begin
            // shared odd factor, so gcd a multiple of it and lcm mostly in range
            wg = $urandom_range(1, 24);
            f0 = rand_of_width(wg) | 63'd1;
            x.operand_a = f0 * rand_of_width($urandom_range(1, OPND_W - wg));
            x.operand_b = f0 * rand_of_width($urandom_range(1, OPND_W - wg));
        end
        else if (pick < 80)
        begin
            x.operand_a = ($urandom_range(1) != 0) ? OPND_MAX : rand_of_width($urandom_range(1, 8));
            x.operand_b = ($urandom_range(1) != 0) ? '0 : rand_of_width($urandom_range(1, OPND_W));
            if ($urandom_range(1) != 0)
            begin
                t = x.operand_a;
                x.operand_a = x.operand_b;
                x.operand_b = t;
            end
        end
        else if (pick < 86)
        begin
            // consecutive Fibonacci numbers: longest Euclidean chains
            k  = $urandom_range(1, 91);
            f0 = 63'd0;
            f1 = 63'd1;
            repeat (k)
            begin
                t  = f0 + f1;
                f0 = f1;
                f1 = t;
            end
            x.operand_a = f1;
            x.operand_b = f0;
        end
        else
        begin
            x.operand_b = rand_of_width($urandom_range(1, 31)) | 63'd1;
            x.operand_a = x.operand_b * rand_of_width($urandom_range(1, 31));
            if ($urandom_range(3) == 0)
                x.operand_a = x.operand_b;
        end
        return x;
    endfunction

    task automatic send_item(input glu_in_t x, input glu_out_t want);
        if (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
            if ($urandom_range(1) != 0)
            begin
                while (busy)
                    @(posedge clk);
            end
            while ($urandom_range(99) < sender_idle_pct)
                @(posedge clk);
        end
        start   <= 1'b1;
        operand <= x;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        expected_results.push_back(want);
        items_sent++;
        if (x.operand_a == 0 || x.operand_b == 0)
            zero_operand_items++;
    endtask

    task automatic report_field(input string name, input logic [OPND_W-1:0] want,
                                input logic [OPND_W-1:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            results_seen++;
            if (result.lcm_overflow === 1'b1)
                overflow_seen++;
            if (expected_results.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, got gcd %0d lcm %0d ovf %0b",
                         $time, result.gcd_value, result.lcm_value, result.lcm_overflow);
                mismatches++;
            end
            else
            begin
                oldest_expected = expected_results.pop_front();
                report_field("gcd_value", oldest_expected.gcd_value, result.gcd_value);
                report_field("lcm_value", oldest_expected.lcm_value, result.lcm_value);
                report_field("lcm_overflow",
                             {{(OPND_W-1){1'b0}}, oldest_expected.lcm_overflow},
                             {{(OPND_W-1){1'b0}}, result.lcm_overflow});
            end
        end
    end

    initial
    begin
        #100_000_000;
        $display("Timeout with %0d results outstanding", expected_results.size());
        $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        rst_n   = 1'b0;
        start   = 1'b0;
        operand = '0;
        mismatches = 0;
        items_sent = 0;
        results_seen = 0;
        overflow_seen = 0;
        zero_operand_items = 0;
        sender_idle_pct = 11;

        dir_rows.push_back(mk_row(63'd0, 63'd0, 1'b1, 63'd0, 63'd0, 1'b0));
        dir_rows.push_back(mk_row(OPND_MAX, 63'd0, 1'b1, OPND_MAX, 63'd0, 1'b0));
        dir_rows.push_back(mk_row(63'd0, OPND_MAX, 1'b1, OPND_MAX, 63'd0, 1'b0));
        dir_rows.push_back(mk_row(63'd1, 63'd0, 1'b1, 63'd1, 63'd0, 1'b0));
        dir_rows.push_back(mk_row(63'd1, 63'd1, 1'b1, 63'd1, 63'd1, 1'b0));
        dir_rows.push_back(mk_row(OPND_MAX, OPND_MAX, 1'b1, OPND_MAX, OPND_MAX, 1'b0));
        dir_rows.push_back(mk_row(OPND_MAX, 63'd1, 1'b1, 63'd1, OPND_MAX, 1'b0));
        dir_rows.push_back(mk_row(63'd1, OPND_MAX, 1'b1, 63'd1, OPND_MAX, 1'b0));
        dir_rows.push_back(mk_row(OPND_MAX, OPND_MAX - 1, 1'b1, 63'd1, OPND_MAX, 1'b1));
        dir_rows.push_back(mk_row(BIT62, BIT62, 1'b1, BIT62, BIT62, 1'b0));
        dir_rows.push_back(mk_row(BIT62, 63'd2, 1'b1, 63'd2, BIT62, 1'b0));
        dir_rows.push_back(mk_row(63'd3, BIT62, 1'b1, 63'd1, OPND_MAX, 1'b1));
        dir_rows.push_back(mk_row(BIT62, BIT62 + 1, 1'b1, 63'd1, OPND_MAX, 1'b1));
        dir_rows.push_back(mk_row(63'd12, 63'd18, 1'b1, 63'd6, 63'd36, 1'b0));
        dir_rows.push_back(mk_row(63'd4660046610375530309, 63'd7540113804746346429));
        dir_rows.push_back(mk_row(63'd7540113804746346429, 63'd4660046610375530309));
        dir_rows.push_back(mk_row(OPND_MAX, 63'd7));
        dir_rows.push_back(mk_row(63'h5555_5555_5555_5555, 63'h2AAA_AAAA_AAAA_AAAA));
        dir_rows.push_back(mk_row(63'd3000000021, 63'd5000000035));
        dir_rows.push_back(mk_row(OPND_MAX - 1, OPND_MAX - 3));

        repeat (7)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
            send_item(dir_rows[i].stim,
                      dir_rows[i].typed ? dir_rows[i].want : gcd_lcm_predict(dir_rows[i].stim));

        for (int phase = 0; phase < 3; phase++)
        begin
            glu_in_t x;
            sender_idle_pct = (phase == 0) ? 11 : (phase == 1) ? 53 : 0;
            repeat (90)
            begin
                x = rand_operands();
                send_item(x, gcd_lcm_predict(x));
            end
        end
        start <= 1'b0;

        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);

        $display("Sent %0d items (%0d with a zero operand) across three sender idle patterns.",
                 items_sent, zero_operand_items);
        $display("Checked %0d results, %0d of them with a saturated lcm.",
                 results_seen, overflow_seen);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
